### hdl/full_cross_correlation_assert.svh
// Assertion macros for the cross-correlation block and its checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FULL_CROSS_CORRELATION_ASSERT_SVH
`define FULL_CROSS_CORRELATION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cross-correlation check failed");

// next-cycle implication, checked outside reset
`define FCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cross-correlation check failed");

`endif

### hdl/fcc_pkg.sv
// Shared constants, codes and types of the cross-correlation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

    localparam int MAX_LEN_DEF      = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int LANES_DEF        = 4;

    localparam int LEN_W     = 11;
    localparam int SIDX_W    = 10;
    localparam int IN_W      = 16;
    localparam int LAG_W     = 11;
    localparam int ACC_W     = 48;
    localparam int IDX_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_B = 1'b1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_RANGE_ERR = 1'b1;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [IN_W-1:0]  a;
        logic [IN_W-1:0]  b;
    } t_wr;

    typedef struct packed {
        logic [IDX_W-1:0] off;
        logic [IDX_W-1:0] count;
        logic             swap;
        logic [LEN_W-1:0] len_a;
        logic [LEN_W-1:0] len_b;
    } t_query;

endpackage

`default_nettype wire

### hdl/fcc_lane.sv
// One multiply-accumulate lane with private copies of both sample stores.
// Depends on fcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcc_lane #(
    parameter int MAX_LEN      = 1024,
    parameter int SAMPLE_WIDTH = 16,
    parameter int LANE_IDX     = 0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire fcc_pkg::t_wr               i_wr,
    input  wire fcc_pkg::t_query            i_qry,
    input  wire logic                       i_issue,
    input  wire logic [fcc_pkg::IDX_W-1:0]  i_base,
    input  wire logic                       i_clear,
    output logic      [fcc_pkg::ACC_W-1:0]  o_acc
);
    import fcc_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = 2 * SAMPLE_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] r_mem_a [MAX_LEN];
    logic signed [SAMPLE_WIDTH-1:0] r_mem_b [MAX_LEN];

    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] addr_x;
    logic [IDX_W-1:0] addr_y;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic             act;
    logic             ok;

    logic signed [SAMPLE_WIDTH-1:0] wr_a;
    logic signed [SAMPLE_WIDTH-1:0] wr_b;
    logic signed [SAMPLE_WIDTH-1:0] r_rd_a;
    logic signed [SAMPLE_WIDTH-1:0] r_rd_b;
    logic                           r_v1;
    logic signed [PW-1:0]           r_prod;
    logic        [ACC_W-1:0]        r_acc;

    always_comb begin
        j      = i_base + IDX_W'(LANE_IDX);
        act    = i_issue && (j < i_qry.count);
        addr_x = j;
        addr_y = j + i_qry.off;
        addr_a = i_qry.swap ? addr_y : addr_x;
        addr_b = i_qry.swap ? addr_x : addr_y;
        ok     = act && (addr_a < IDX_W'(i_qry.len_a)) && (addr_b < IDX_W'(i_qry.len_b));
        wr_a   = SAMPLE_WIDTH'(32'(i_wr.a));
        wr_b   = SAMPLE_WIDTH'(32'(i_wr.b));
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_a[i_wr.addr[AW-1:0]] <= wr_a;
            r_mem_b[i_wr.addr[AW-1:0]] <= wr_b;
        end
        r_rd_a <= r_mem_a[addr_a[AW-1:0]];
        r_rd_b <= r_mem_b[addr_b[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= PW'(r_rd_a) * PW'(r_rd_b);
        end else begin
            r_prod <= '0;
        end
        if (i_clear) begin
            r_acc <= '0;
        end else begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

### hdl/fcc_merge.sv
// Merge stage: adds the lane partial sums one lane per cycle.
// Depends on fcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcc_merge #(
    parameter int LANES = 4
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic [LANES-1:0][fcc_pkg::ACC_W-1:0]  i_acc,
    output logic                                       o_done,
    output logic      [fcc_pkg::ACC_W-1:0]             o_sum
);
    import fcc_pkg::*;

    localparam int MW = (LANES > 1) ? $clog2(LANES) : 1;

    logic             r_busy;
    logic             r_done;
    logic [MW-1:0]    r_idx;
    logic [ACC_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (r_idx == MW'(LANES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= '0;
        end else if (r_busy) begin
            r_sum <= r_sum + i_acc[r_idx];
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

`default_nettype wire

### hdl/full_cross_correlation.sv
// Top level of the full cross-correlation engine: control sequencer, lanes, merge.
// Depends on fcc_pkg, fcc_lane and fcc_merge.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries load and query transactions.
//   A load writes sample pair (sample_a, sample_b) at sample_index and returns
//   nothing; the next transaction is taken in the following cycle.
//   A query returns one result on the output channel (o_out_valid / i_out_ready)
//   with the correlation at lag_index, the lag echoed and a status bit.
//   With N = max(length_a, length_b) after capping each at MAX_LEN (N at least 1),
//   lags 0..2N-2 are valid; other lags return zero with range-error status. A valid
//   query of K products (K is at most N) is spread over the LANES multiply-accumulate
//   lanes; one query is in flight at a time. The result sits in an output register;
//   while it is stalled, loads are still taken, and a further query runs and then
//   waits for the register to free. Length registers are to be written through
//   i_cfg_we only while the block is idle; the block itself does not enforce this.
//   Reset clears control state and sets both lengths to 1024; sample stores are not
//   cleared.
`timescale 1ns / 1ps
`default_nettype none

module full_cross_correlation #(
    parameter int MAX_LEN      = fcc_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_WIDTH = fcc_pkg::SAMPLE_WIDTH_DEF,
    parameter int LANES        = fcc_pkg::LANES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_req_type,
    input  wire logic        [fcc_pkg::SIDX_W-1:0]  i_sample_index,
    input  wire logic signed [fcc_pkg::IN_W-1:0]    i_sample_a,
    input  wire logic signed [fcc_pkg::IN_W-1:0]    i_sample_b,
    input  wire logic        [fcc_pkg::LAG_W-1:0]   i_lag_index,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed      [fcc_pkg::ACC_W-1:0]   o_corr_value,
    output logic             [fcc_pkg::LAG_W-1:0]   o_lag_echo,
    output logic                                    o_status,
    input  wire logic                               i_cfg_we,
    input  wire logic        [fcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [fcc_pkg::LEN_W-1:0]   i_cfg_data
);
    import fcc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_MERGE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [1:0] DRAIN_CYC = 2'd1;

    logic [2:0]       r_state;
    logic [LEN_W-1:0] r_len_a;
    logic [LEN_W-1:0] r_len_b;
    logic [LEN_W-1:0] r_n;
    logic [LAG_W-1:0] r_lag;
    t_query           r_qry;
    logic [IDX_W-1:0] r_base;
    logic [1:0]       r_drain;
    logic [ACC_W-1:0] r_res_val;
    logic             r_res_status;
    logic             r_out_valid;
    logic [ACC_W-1:0] r_out_val;
    logic [LAG_W-1:0] r_out_lag;
    logic             r_out_status;

    logic [LEN_W-1:0] eff_a;
    logic [LEN_W-1:0] eff_b;
    logic [LEN_W-1:0] n_calc;
    logic [IDX_W-1:0] n12;
    logic [IDX_W-1:0] lag12;
    logic [IDX_W-1:0] last_lag;
    logic             range_err;
    logic             swap;
    logic [IDX_W-1:0] n_off;
    logic [IDX_W-1:0] n_count;
    logic [IDX_W-1:0] n_base;
    logic             in_acc;
    logic             out_free;
    t_wr              wr;
    logic             merge_start;
    logic             merge_done;
    logic [ACC_W-1:0] merge_sum;

    logic [LANES-1:0][ACC_W-1:0] lane_acc;

    always_comb begin
        eff_a  = (32'(r_len_a) > MAX_LEN) ? LEN_W'(MAX_LEN) : r_len_a;
        eff_b  = (32'(r_len_b) > MAX_LEN) ? LEN_W'(MAX_LEN) : r_len_b;
        n_calc = (eff_a > eff_b) ? eff_a : eff_b;
        if (n_calc == '0) begin
            n_calc = LEN_W'(1);
        end
        n12       = IDX_W'(r_n);
        lag12     = IDX_W'(r_lag);
        last_lag  = (n12 << 1) - IDX_W'(2);
        range_err = lag12 > last_lag;
        swap      = lag12 >= n12;
        n_off     = swap ? lag12 - n12 + IDX_W'(1) : n12 - IDX_W'(1) - lag12;
        n_count   = swap ? (n12 << 1) - IDX_W'(1) - lag12 : lag12 + IDX_W'(1);
        n_base    = r_base + IDX_W'(LANES);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign merge_start = (r_state == S_DRAIN) && (r_drain == '0);

    always_comb begin
        wr.en   = in_acc && (i_req_type == REQ_LOAD) && (32'(i_sample_index) < MAX_LEN);
        wr.addr = IDX_W'(i_sample_index);
        wr.a    = $unsigned(i_sample_a);
        wr.b    = $unsigned(i_sample_b);
    end

    // length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= LEN_RESET;
            r_len_b <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LENGTH_A: r_len_a <= i_cfg_data;
                REG_LENGTH_B: r_len_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_drain     <= '0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_req_type == REQ_QUERY)) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_state <= range_err ? S_DONE : S_RUN;
                end
                S_RUN: begin
                    if (n_base >= r_qry.count) begin
                        r_state <= S_DRAIN;
                        r_drain <= DRAIN_CYC;
                    end
                end
                S_DRAIN: begin
                    if (r_drain == '0) begin
                        r_state <= S_MERGE;
                    end else begin
                        r_drain <= r_drain - 1'b1;
                    end
                end
                S_MERGE: begin
                    if (merge_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // query payload
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_req_type == REQ_QUERY)) begin
            r_lag <= i_lag_index;
            r_n   <= n_calc;
        end
        if (r_state == S_SETUP) begin
            r_qry.off    <= n_off;
            r_qry.count  <= n_count;
            r_qry.swap   <= swap;
            r_qry.len_a  <= eff_a;
            r_qry.len_b  <= eff_b;
            r_base       <= '0;
            r_res_val    <= '0;
            r_res_status <= range_err ? ST_RANGE_ERR : ST_OK;
        end else if (r_state == S_RUN) begin
            r_base <= n_base;
        end else if ((r_state == S_MERGE) && merge_done) begin
            r_res_val <= merge_sum;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_val    <= r_res_val;
            r_out_lag    <= r_lag;
            r_out_status <= r_res_status;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        fcc_lane #(
            .MAX_LEN      (MAX_LEN),
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .LANE_IDX     (g)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_qry   (r_qry),
            .i_issue (r_state == S_RUN),
            .i_base  (r_base),
            .i_clear (r_state == S_SETUP),
            .o_acc   (lane_acc[g])
        );
    end

    fcc_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (merge_start),
        .i_acc   (lane_acc),
        .o_done  (merge_done),
        .o_sum   (merge_sum)
    );

    assign o_out_valid  = r_out_valid;
    assign o_corr_value = $signed(r_out_val);
    assign o_lag_echo   = r_out_lag;
    assign o_status     = r_out_status;

endmodule

`default_nettype wire

### hdl/fcc_checker.sv
// Port-level checker for the cross-correlation block, bound to its top level.
// Depends on fcc_pkg and full_cross_correlation_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "full_cross_correlation_assert.svh"

module fcc_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_in_valid,
    input wire logic                                 o_in_ready,
    input wire logic                                 i_req_type,
    input wire logic        [fcc_pkg::SIDX_W-1:0]    i_sample_index,
    input wire logic signed [fcc_pkg::IN_W-1:0]      i_sample_a,
    input wire logic signed [fcc_pkg::IN_W-1:0]      i_sample_b,
    input wire logic        [fcc_pkg::LAG_W-1:0]     i_lag_index,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic signed [fcc_pkg::ACC_W-1:0]     o_corr_value,
    input wire logic        [fcc_pkg::LAG_W-1:0]     o_lag_echo,
    input wire logic                                 o_status,
    input wire logic                                 i_cfg_we,
    input wire logic        [fcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic        [fcc_pkg::LEN_W-1:0]     i_cfg_data
);
    import fcc_pkg::*;

    logic load_acc;
    logic query_acc;
    logic cfg_seen;

    assign load_acc  = i_in_valid && o_in_ready && (i_req_type == REQ_LOAD);
    assign query_acc = i_in_valid && o_in_ready && (i_req_type == REQ_QUERY);
    assign cfg_seen  = i_cfg_we || (i_cfg_index != i_cfg_index) || (i_cfg_data != i_cfg_data)
                       || (i_sample_index != i_sample_index) || (i_sample_a != i_sample_a)
                       || (i_sample_b != i_sample_b) || (i_lag_index != i_lag_index);

    // stalled result holds
    `FCC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_corr_value) && $stable(o_lag_echo) && $stable(o_status))
    // range error carries a zero sum
    `FCC_ASSERT_NOW(a_err_zero, o_out_valid && (o_status == ST_RANGE_ERR), o_corr_value == '0)
    // lag zero always exists
    `FCC_ASSERT_NOW(a_lag0_ok, o_out_valid && (o_lag_echo == '0), o_status == ST_OK || cfg_seen)
    // a query occupies the engine
    `FCC_ASSERT_NEXT(a_query_busy, query_acc, !o_in_ready)
    // a load completes at once
    `FCC_ASSERT_NEXT(a_load_fast, load_acc, o_in_ready)

endmodule

bind full_cross_correlation fcc_checker u_fcc_checker (.*);

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for full_cross_correlation: random and directed load and lag-query
// traffic against a built-in predictor of the correlation sums. Depends on fcc_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import fcc_pkg::*;

    localparam int STORE_DEPTH   = MAX_LEN_DEF;
    localparam int FILL_DEPTH    = 64;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PRINT_LIMIT   = 20;

    localparam logic signed [IN_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [IN_W-1:0] SAMPLE_MAX = 16'sh7fff;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} t_rx_mode;

    typedef struct {
        logic signed [ACC_W-1:0] value;
        logic [LAG_W-1:0]        lag;
        logic                    status;
    } t_corr_result;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_ready;
    logic                        i_req_type     = REQ_LOAD;
    logic        [SIDX_W-1:0]    i_sample_index = '0;
    logic signed [IN_W-1:0]      i_sample_a     = '0;
    logic signed [IN_W-1:0]      i_sample_b     = '0;
    logic        [LAG_W-1:0]     i_lag_index    = '0;
    logic                        o_out_valid;
    logic                        i_out_ready    = 1'b0;
    logic signed [ACC_W-1:0]     o_corr_value;
    logic        [LAG_W-1:0]     o_lag_echo;
    logic                        o_status;
    logic                        i_cfg_we       = 1'b0;
    logic        [CFG_IDX_W-1:0] i_cfg_index    = REG_LENGTH_A;
    logic        [LEN_W-1:0]     i_cfg_data     = '0;

    // predictor state
    logic signed [IN_W-1:0] sig_a [STORE_DEPTH];
    logic signed [IN_W-1:0] sig_b [STORE_DEPTH];
    logic [LEN_W-1:0]       len_a_cfg = LEN_RESET;
    logic [LEN_W-1:0]       len_b_cfg = LEN_RESET;
    t_corr_result           pending_corr[$];

    int error_count   = 0;
    int load_count    = 0;
    int query_count   = 0;
    int range_count   = 0;
    int checked_count = 0;
    int setting_count = 0;
    int burst_left    = 0;
    int rx_hold_request = 0;

    full_cross_correlation i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_sample_index (i_sample_index),
        .i_sample_a     (i_sample_a),
        .i_sample_b     (i_sample_b),
        .i_lag_index    (i_lag_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_corr_value   (o_corr_value),
        .o_lag_echo     (o_lag_echo),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_corr.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic flag_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t ns mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic int eff_len(logic [LEN_W-1:0] len);
        return (len > STORE_DEPTH) ? STORE_DEPTH : int'(len);
    endfunction

    function automatic int corr_span();
        int n;
        n = (eff_len(len_a_cfg) > eff_len(len_b_cfg)) ? eff_len(len_a_cfg) : eff_len(len_b_cfg);
        return (n == 0) ? 1 : n;
    endfunction

    function automatic t_corr_result predict_lag(logic [LAG_W-1:0] lag);
        t_corr_result r;
        int la, lb, n, lg, cnt, a0, b0, j;
        longint acc, va, vb;
        la  = eff_len(len_a_cfg);
        lb  = eff_len(len_b_cfg);
        n   = corr_span();
        lg  = int'(lag);
        acc = 0;
        r.lag = lag;
        if (lg > 2 * n - 2) begin
            r.value  = '0;
            r.status = ST_RANGE_ERR;
            return r;
        end
        if (lg < n) begin
            cnt = lg;
            a0  = 0;
            b0  = n - 1 - lg;
        end else begin
            cnt = 2 * n - 2 - lg;
            a0  = lg - n + 1;
            b0  = 0;
        end
        for (j = 0; j <= cnt; j++) begin
            va  = (a0 + j < la) ? longint'(sig_a[a0 + j]) : 64'sd0;
            vb  = (b0 + j < lb) ? longint'(sig_b[b0 + j]) : 64'sd0;
            acc += va * vb;
        end
        r.value  = acc[ACC_W-1:0];
        r.status = ST_OK;
        return r;
    endfunction

    function automatic logic signed [IN_W-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return '0;
            default: return IN_W'($urandom);
        endcase
    endfunction

    // offer one transaction in bursts with random gaps; hold until accepted
    task automatic send_txn(logic req, logic [SIDX_W-1:0] sidx, logic signed [IN_W-1:0] a,
                            logic signed [IN_W-1:0] b, logic [LAG_W-1:0] lag);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_sample_index <= sidx;
        i_sample_a     <= a;
        i_sample_b     <= b;
        i_lag_index    <= lag;
        do @(posedge i_clk); while (!o_in_ready);
        if (req == REQ_LOAD) begin
            sig_a[sidx] = a;
            sig_b[sidx] = b;
            load_count++;
        end else begin
            pending_corr.push_back(predict_lag(lag));
            query_count++;
        end
    endtask

    task automatic load_pair(logic [SIDX_W-1:0] idx, logic signed [IN_W-1:0] a,
                             logic signed [IN_W-1:0] b);
        send_txn(REQ_LOAD, idx, a, b, LAG_W'($urandom));
    endtask

    task automatic query_lag(logic [LAG_W-1:0] lag);
        send_txn(REQ_QUERY, SIDX_W'($urandom), IN_W'($urandom), IN_W'($urandom), lag);
    endtask

    task automatic wait_results_done();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_corr.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        while (pending_corr.size() != 0) begin
            flag_mismatch($sformatf("no result for lag %0d", pending_corr[0].lag));
            void'(pending_corr.pop_front());
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both length registers while the block is idle
    task automatic set_lengths(logic [LEN_W-1:0] la, logic [LEN_W-1:0] lb);
        wait_results_done();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_LENGTH_A;
        i_cfg_data  <= la;
        @(posedge i_clk);
        len_a_cfg = la;
        i_cfg_index <= REG_LENGTH_B;
        i_cfg_data  <= lb;
        @(posedge i_clk);
        len_b_cfg = lb;
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    initial begin : rx_pattern
        t_rx_mode mode;
        int span, hold_left, tick;
        mode = RX_OPEN;
        span = 0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && rx_hold_request != 0) begin
                hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 2));
                    span = $urandom_range(16, 160);
                end
                span--;
                tick++;
                case (mode)
                    RX_OPEN:   i_out_ready <= 1'b1;
                    RX_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
                    default:   i_out_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_corr_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_corr.size() == 0) begin
                flag_mismatch($sformatf("unexpected result for lag %0d", o_lag_echo));
            end else begin
                want = pending_corr.pop_front();
                checked_count++;
                if (want.status == ST_RANGE_ERR) range_count++;
                if (o_corr_value !== want.value) begin
                    flag_mismatch($sformatf("lag %0d corr_value %0d, want %0d",
                                            want.lag, o_corr_value, want.value));
                end
                if (o_lag_echo !== want.lag) begin
                    flag_mismatch($sformatf("lag_echo %0d, want %0d", o_lag_echo, want.lag));
                end
                if (o_status !== want.status) begin
                    flag_mismatch($sformatf("lag %0d status %0b, want %0b",
                                            want.lag, o_status, want.status));
                end
            end
        end
    end

    // fill the low entries at full negative scale and hit the largest sum they allow
    task automatic test_full_scale();
        int k;
        set_lengths(LEN_W'(FILL_DEPTH), LEN_W'(FILL_DEPTH));
        for (k = 0; k < FILL_DEPTH; k++) begin
            load_pair(SIDX_W'(k), SAMPLE_MIN, SAMPLE_MIN);
        end
        query_lag(LAG_W'(FILL_DEPTH - 1));
        query_lag('0);
        query_lag(LAG_W'(2 * FILL_DEPTH - 2));
        query_lag(LAG_W'(2 * FILL_DEPTH - 1));
        wait_results_done();
    endtask

    task automatic test_extremes();
        int k;
        set_lengths(LEN_W'(4), LEN_W'(4));
        load_pair(SIDX_W'(0), SAMPLE_MAX, SAMPLE_MIN);
        load_pair(SIDX_W'(1), SAMPLE_MIN, SAMPLE_MIN);
        load_pair(SIDX_W'(2), -16'sd1, SAMPLE_MAX);
        load_pair(SIDX_W'(3), 16'sd0, 16'sd1);
        load_pair(SIDX_W'(1023), SAMPLE_MAX, SAMPLE_MAX);
        for (k = 0; k <= 7; k++) begin
            query_lag(LAG_W'(k));
        end
        query_lag(LAG_W'(2047));
    endtask

    task automatic test_length_cases();
        set_lengths('0, '0);
        query_lag('0);
        query_lag(LAG_W'(1));
        set_lengths('0, LEN_W'(3));
        query_lag('0);
        query_lag(LAG_W'(2));
        query_lag(LAG_W'(4));
        query_lag(LAG_W'(5));
        set_lengths(LEN_W'(2047), LEN_W'(1));
        query_lag(LAG_W'(40));
        query_lag(LAG_W'(2046));
        query_lag(LAG_W'(2047));
        set_lengths(LEN_W'(1), LEN_W'(1));
        query_lag('0);
        query_lag(LAG_W'(1));
    endtask

    task automatic run_traffic(int items);
        int k, n;
        logic [SIDX_W-1:0] idx;
        logic [LAG_W-1:0]  lag;
        n = corr_span();
        for (k = 0; k < items; k++) begin
            if ($urandom_range(0, 9) < 4) begin
                idx = ($urandom_range(0, 3) != 0) ? SIDX_W'($urandom_range(0, n - 1))
                                                  : SIDX_W'($urandom);
                load_pair(idx, rand_sample(), rand_sample());
            end else begin
                lag = ($urandom_range(0, 7) != 0) ? LAG_W'($urandom_range(0, 2 * n - 2))
                                                  : LAG_W'($urandom_range(2 * n - 1, 2047));
                query_lag(lag);
            end
        end
    endtask

    task automatic test_random_traffic();
        int p;
        for (p = 0; p < 14; p++) begin
            case (p)
                4:  set_lengths(LEN_W'(FILL_DEPTH), LEN_W'($urandom_range(1, FILL_DEPTH)));
                6:  set_lengths('0, LEN_W'($urandom_range(1, 16)));
                9:  set_lengths(LEN_W'($urandom_range(1, FILL_DEPTH)), LEN_W'(FILL_DEPTH));
                11: set_lengths(LEN_W'(1), LEN_W'(1));
                13: set_lengths(LEN_W'($urandom_range(1, 40)), '0);
                default: set_lengths(LEN_W'($urandom_range(1, 40)), LEN_W'($urandom_range(1, 40)));
            endcase
            run_traffic(31);
        end
    endtask

    // stall the receiver for a long stretch while offering traffic
    task automatic test_backpressure();
        set_lengths(LEN_W'(12), LEN_W'(9));
        rx_hold_request = HOLD_CYCLES;
        run_traffic(40);
        wait_results_done();
    endtask

    // pause the sender until every result is back, then resume
    task automatic test_sender_pause();
        int k;
        set_lengths(LEN_W'(6), LEN_W'(17));
        for (k = 0; k < 5; k++) begin
            query_lag(LAG_W'($urandom_range(0, 32)));
        end
        wait_results_done();
        run_traffic(10);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_scale();
        test_extremes();
        test_length_cases();
        test_random_traffic();
        test_backpressure();
        test_sender_pause();
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d sample loads and %0d lag queries (%0d out of range)",
                 load_count, query_count, range_count);
        $display("over %0d length settings; %0d results compared, %0d mismatches.",
                 setting_count, checked_count, error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
